// ===== src/card_feed_motor_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Card feed motor sequencer: assertion macros
// Shared helpers for the concurrent checks in the RTL files.
// ----------------------------------------------------------------------------
`ifndef CARD_FEED_MOTOR_SEQUENCER_DEFINES_SVH
`define CARD_FEED_MOTOR_SEQUENCER_DEFINES_SVH

// Clocked check on clk, disabled while rst is high.
`define CFMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check on clk that also holds during reset.
`define CFMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/cfms_pkg.sv =====
// ----------------------------------------------------------------------------
// Card feed motor sequencer package
// Types, register indexes, reset values and result codes.
// ----------------------------------------------------------------------------
package cfms_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;
  localparam int InDataWidth   = 8;
  localparam int OutDataWidth  = 24;

  // Register indexes on the configuration port.
  localparam logic [CfgIndexWidth-1:0] CFG_FAST_POLL      = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_SLOW_POLL      = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_FEED_LIMIT     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_DRAW_LIMIT     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_EJECT_LIMIT    = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_EJECT_PREDELAY = 3'd5;
  localparam logic [CfgIndexWidth-1:0] CFG_BACKOFF        = 3'd6;
  localparam logic [CfgIndexWidth-1:0] CFG_ERROR_LIMIT    = 3'd7;

  // Register reset values.
  localparam logic [7:0]  RST_FAST_POLL      = 8'd10;
  localparam logic [7:0]  RST_SLOW_POLL      = 8'd50;
  localparam logic [7:0]  RST_FEED_LIMIT     = 8'd50;
  localparam logic [7:0]  RST_DRAW_LIMIT     = 8'd150;
  localparam logic [7:0]  RST_EJECT_LIMIT    = 8'd40;
  localparam logic [9:0]  RST_EJECT_PREDELAY = 10'd100;
  localparam logic [15:0] RST_BACKOFF        = 16'd30000;
  localparam logic [7:0]  RST_ERROR_LIMIT    = 8'd2;

  // Load and eject outcome codes.
  localparam logic [1:0] LOAD_OK        = 2'd0;
  localparam logic [1:0] LOAD_TIMEOUT   = 2'd1;
  localparam logic [1:0] LOAD_TOO_LONG  = 2'd2;
  localparam logic [1:0] LOAD_TOO_SHORT = 2'd3;
  localparam logic       EJECT_OK       = 1'b0;
  localparam logic       EJECT_TIMEOUT  = 1'b1;

  typedef struct packed {
    logic [7:0]  fast_poll_ticks;
    logic [7:0]  slow_poll_ticks;
    logic [7:0]  feed_limit;
    logic [7:0]  draw_limit;
    logic [7:0]  eject_limit;
    logic [9:0]  eject_predelay_ticks;
    logic [15:0] backoff_ticks;
    logic [7:0]  error_limit;
  } cfg_t;

  typedef struct packed {
    logic switch_one_level;
    logic switch_two_level;
    logic switch_three_level;
    logic host_done_level;
  } item_t;

  typedef struct packed {
    logic       motor_in_on;
    logic       motor_out_on;
    logic       card_ready;
    logic [3:0] phase;
    logic       load_result_valid;
    logic [1:0] load_result;
    logic       eject_result_valid;
    logic       eject_result;
    logic [7:0] fault_level;
  } result_t;

endpackage

// ===== src/cfms_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Card feed motor sequencer: configuration registers
// Holds the eight timing and limit registers written by the host port.
// ----------------------------------------------------------------------------
module cfms_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cfms_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [cfms_pkg::CfgDataWidth-1:0]   cfg_data,
  output cfms_pkg::cfg_t                      cfg
);
  import cfms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_poll_ticks      <= RST_FAST_POLL;
      cfg.slow_poll_ticks      <= RST_SLOW_POLL;
      cfg.feed_limit           <= RST_FEED_LIMIT;
      cfg.draw_limit           <= RST_DRAW_LIMIT;
      cfg.eject_limit          <= RST_EJECT_LIMIT;
      cfg.eject_predelay_ticks <= RST_EJECT_PREDELAY;
      cfg.backoff_ticks        <= RST_BACKOFF;
      cfg.error_limit          <= RST_ERROR_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAST_POLL:      cfg.fast_poll_ticks      <= cfg_data[7:0];
        CFG_SLOW_POLL:      cfg.slow_poll_ticks      <= cfg_data[7:0];
        CFG_FEED_LIMIT:     cfg.feed_limit           <= cfg_data[7:0];
        CFG_DRAW_LIMIT:     cfg.draw_limit           <= cfg_data[7:0];
        CFG_EJECT_LIMIT:    cfg.eject_limit          <= cfg_data[7:0];
        CFG_EJECT_PREDELAY: cfg.eject_predelay_ticks <= cfg_data[9:0];
        CFG_BACKOFF:        cfg.backoff_ticks        <= cfg_data;
        CFG_ERROR_LIMIT:    cfg.error_limit          <= cfg_data[7:0];
        default:            cfg.error_limit          <= cfg.error_limit;
      endcase
    end
  end

endmodule

// ===== src/cfms_core.sv =====
// ----------------------------------------------------------------------------
// Card feed motor sequencer: sequencing core
// Phase machine with a tick timer, a poll counter and a fault count; one tick per step.
// ----------------------------------------------------------------------------
`include "card_feed_motor_sequencer_defines.svh"

module cfms_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  cfms_pkg::item_t   item,
  input  cfms_pkg::cfg_t    cfg,
  output cfms_pkg::result_t result
);
  import cfms_pkg::*;

  typedef enum logic [3:0] {
    PH_STARTUP     = 4'd0,
    PH_WAIT_INSERT = 4'd1,
    PH_SETTLE      = 4'd2,
    PH_FEED        = 4'd3,
    PH_DRAW        = 4'd4,
    PH_READY       = 4'd5,
    PH_EJ_DELAY    = 4'd6,
    PH_EJ_RUN      = 4'd7,
    PH_RUNOUT      = 4'd8,
    PH_BACKOFF     = 4'd9
  } phase_t;

  phase_t      phase_reg, phase_next;
  logic [15:0] tick_timer, tick_timer_next;
  logic [8:0]  poll_count, poll_count_next;
  logic [1:0]  previous_switches, previous_switches_next;
  logic [7:0]  fault_count, fault_count_next;
  logic        ready_latch, ready_latch_next;
  logic        startup_eject, startup_eject_next;

  logic        lvalid, evalid, eres;
  logic [1:0]  lres;
  logic        delay_running;
  logic [1:0]  sample;
  logic [1:0]  prev_raised;
  logic [8:0]  limit_plus_one;
  logic [7:0]  fault_inc;
  logic        poll_switch;

  assign delay_running = tick_timer > 16'd1;
  assign sample        = {item.switch_two_level, item.switch_one_level};
  assign prev_raised   = (sample > previous_switches) ? sample : previous_switches;
  assign fault_inc     = (fault_count == 8'hFF) ? fault_count : fault_count + 8'd1;

  always_comb begin
    unique case (phase_reg)
      PH_FEED:   limit_plus_one = {1'b0, cfg.feed_limit} + 9'd1;
      PH_DRAW:   limit_plus_one = {1'b0, cfg.draw_limit} + 9'd1;
      default:   limit_plus_one = {1'b0, cfg.eject_limit} + 9'd1;
    endcase
    poll_switch = (phase_reg == PH_FEED) ? item.switch_two_level
                                         : item.switch_three_level;
  end

  always_comb begin
    phase_next             = phase_reg;
    tick_timer_next        = tick_timer;
    poll_count_next        = poll_count;
    previous_switches_next = previous_switches;
    fault_count_next       = fault_count;
    ready_latch_next       = ready_latch;
    startup_eject_next     = startup_eject;
    lvalid = 1'b0;
    lres   = LOAD_OK;
    evalid = 1'b0;
    eres   = EJECT_OK;

    unique case (phase_reg)
      PH_WAIT_INSERT: begin
        if (delay_running) begin
          tick_timer_next = tick_timer - 16'd1;
        end else begin
          previous_switches_next = prev_raised;
          // A falling sample after a rise, or both switches closed, is an insert.
          if (sample < prev_raised || sample == 2'd0) begin
            phase_next      = PH_SETTLE;
            tick_timer_next = {8'd0, cfg.slow_poll_ticks};
            poll_count_next = 9'd0;
          end else begin
            poll_count_next = poll_count + 9'd1;
            tick_timer_next = {8'd0, cfg.slow_poll_ticks};
          end
        end
      end
      PH_SETTLE: begin
        if (delay_running) begin
          tick_timer_next = tick_timer - 16'd1;
        end else begin
          phase_next      = PH_FEED;
          tick_timer_next = 16'd0;
          poll_count_next = 9'd0;
        end
      end
      PH_FEED, PH_DRAW: begin
        if (delay_running) begin
          tick_timer_next = tick_timer - 16'd1;
        end else if (poll_count > limit_plus_one) begin
          lvalid             = 1'b1;
          lres               = LOAD_TIMEOUT;
          fault_count_next   = fault_inc;
          startup_eject_next = 1'b0;
          phase_next         = PH_EJ_DELAY;
          tick_timer_next    = {6'd0, cfg.eject_predelay_ticks};
          poll_count_next    = 9'd0;
        end else if (poll_switch) begin
          poll_count_next = poll_count + 9'd1;
          tick_timer_next = {8'd0, cfg.fast_poll_ticks};
        end else if (phase_reg == PH_FEED) begin
          phase_next      = PH_DRAW;
          tick_timer_next = 16'd0;
          poll_count_next = 9'd0;
        end else begin
          lvalid             = 1'b1;
          startup_eject_next = 1'b0;
          poll_count_next    = 9'd0;
          if (!item.switch_one_level) begin
            lres = LOAD_TOO_LONG;
          end else if (item.switch_two_level) begin
            lres = LOAD_TOO_SHORT;
          end else begin
            lres = LOAD_OK;
          end
          if (lres == LOAD_OK) begin
            ready_latch_next = 1'b1;
            phase_next       = PH_READY;
            tick_timer_next  = 16'd0;
          end else begin
            fault_count_next = fault_inc;
            phase_next       = PH_EJ_DELAY;
            tick_timer_next  = {6'd0, cfg.eject_predelay_ticks};
          end
        end
      end
      PH_READY: begin
        if (!item.host_done_level) begin
          ready_latch_next = 1'b0;
          phase_next       = PH_EJ_DELAY;
          tick_timer_next  = {6'd0, cfg.eject_predelay_ticks};
          poll_count_next  = 9'd0;
        end
      end
      PH_EJ_DELAY: begin
        if (delay_running) begin
          tick_timer_next = tick_timer - 16'd1;
        end else begin
          phase_next      = PH_EJ_RUN;
          tick_timer_next = 16'd0;
          poll_count_next = 9'd0;
        end
      end
      PH_EJ_RUN: begin
        if (delay_running) begin
          tick_timer_next = tick_timer - 16'd1;
        end else if (poll_count > limit_plus_one) begin
          evalid          = 1'b1;
          eres            = EJECT_TIMEOUT;
          poll_count_next = 9'd0;
          if (startup_eject) begin
            startup_eject_next     = 1'b0;
            previous_switches_next = 2'd0;
            phase_next             = PH_WAIT_INSERT;
            tick_timer_next        = 16'd0;
          end else begin
            fault_count_next = fault_inc;
            if (fault_inc > cfg.error_limit) begin
              phase_next      = PH_BACKOFF;
              tick_timer_next = cfg.backoff_ticks;
            end else begin
              previous_switches_next = 2'd0;
              phase_next             = PH_WAIT_INSERT;
              tick_timer_next        = 16'd0;
            end
          end
        end else if (item.switch_two_level) begin
          phase_next      = PH_RUNOUT;
          tick_timer_next = {8'd0, cfg.slow_poll_ticks};
          poll_count_next = 9'd0;
        end else begin
          poll_count_next = poll_count + 9'd1;
          tick_timer_next = {8'd0, cfg.slow_poll_ticks};
        end
      end
      PH_RUNOUT: begin
        if (delay_running) begin
          tick_timer_next = tick_timer - 16'd1;
        end else begin
          evalid = 1'b1;
          eres   = EJECT_OK;
          if (!startup_eject) begin
            fault_count_next = 8'd0;
          end
          startup_eject_next     = 1'b0;
          previous_switches_next = 2'd0;
          phase_next             = PH_WAIT_INSERT;
          tick_timer_next        = 16'd0;
          poll_count_next        = 9'd0;
        end
      end
      PH_BACKOFF: begin
        if (delay_running) begin
          tick_timer_next = tick_timer - 16'd1;
        end else begin
          previous_switches_next = 2'd0;
          phase_next             = PH_WAIT_INSERT;
          tick_timer_next        = 16'd0;
          poll_count_next        = 9'd0;
        end
      end
      default: begin
        // Startup, and any code outside the phase list: eject a card left inside.
        poll_count_next = 9'd0;
        if (!item.switch_two_level) begin
          startup_eject_next = 1'b1;
          phase_next         = PH_EJ_DELAY;
          tick_timer_next    = {6'd0, cfg.eject_predelay_ticks};
        end else begin
          startup_eject_next     = 1'b0;
          previous_switches_next = 2'd0;
          phase_next             = PH_WAIT_INSERT;
          tick_timer_next        = 16'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg         <= PH_STARTUP;
      tick_timer        <= 16'd0;
      poll_count        <= 9'd0;
      previous_switches <= 2'd0;
      fault_count       <= 8'd0;
      ready_latch       <= 1'b0;
      startup_eject     <= 1'b0;
      result            <= '0;
    end else if (step) begin
      phase_reg                 <= phase_next;
      tick_timer                <= tick_timer_next;
      poll_count                <= poll_count_next;
      previous_switches         <= previous_switches_next;
      fault_count               <= fault_count_next;
      ready_latch               <= ready_latch_next;
      startup_eject             <= startup_eject_next;
      result.motor_in_on        <= (phase_next == PH_FEED) || (phase_next == PH_DRAW);
      result.motor_out_on       <= (phase_next == PH_EJ_RUN) || (phase_next == PH_RUNOUT);
      result.card_ready         <= ready_latch_next;
      result.phase              <= phase_next;
      result.load_result_valid  <= lvalid;
      result.load_result        <= lres;
      result.eject_result_valid <= evalid;
      result.eject_result       <= eres;
      result.fault_level        <= fault_count_next;
    end
  end

  // The ready flag is set on entry to the ready phase and cleared on leaving it.
  `CFMS_ASSERT(a_ready_matches_phase, ready_latch == (phase_reg == PH_READY),
               "card ready flag out of step with ready phase")

  `CFMS_ASSERT(a_motor_exclusive, !(result.motor_in_on && result.motor_out_on),
               "motor driven both ways")

  // A finished load always leads to the ready phase or the eject wait.
  `CFMS_ASSERT(a_load_next_phase,
               !result.load_result_valid || result.phase == PH_READY
               || result.phase == PH_EJ_DELAY,
               "load result reported outside a load exit")

  `CFMS_ASSERT(a_eject_next_phase,
               !result.eject_result_valid || result.phase == PH_WAIT_INSERT
               || result.phase == PH_BACKOFF,
               "eject result reported outside an eject exit")

endmodule

// ===== src/card_feed_motor_sequencer.sv =====
// ----------------------------------------------------------------------------
// Card feed motor sequencer
// Steps the card feed phase machine once per tick transfer and streams the
// motor, ready and outcome levels out, one result per tick.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Payload
//  s_axis_*  | in        | tdata[3:0]: switch one, two, three, host done levels
//  m_axis_*  | out       | tdata[19:0]: motor, ready, phase, results, fault count
//  cfg_*     | in        | write enable, register index, 16-bit data
//
// One tick per clock cycle while the output is not stalled; a tick waits in the
// input register after transfer and its result then goes to the result register.
// Each tick's state update is one pass through the phase logic, so the
// next tick can follow in the next cycle.
// Synchronous reset puts the machine in the startup phase with its state and
// config registers at their defaults. A stall on the output holds the result
// register and the input register; s_axis_tready falls only when both are full.
// ----------------------------------------------------------------------------
`include "card_feed_motor_sequencer_defines.svh"

module card_feed_motor_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  // switch_one_level, switch_two_level, switch_three_level, host_done_level
  input  logic [cfms_pkg::InDataWidth-1:0]    s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // motor_in_on, motor_out_on, card_ready, phase[3:0], load_result_valid,
  // load_result[1:0], eject_result_valid, eject_result, fault_level[7:0]
  output logic [cfms_pkg::OutDataWidth-1:0]   m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we,
  input  logic [cfms_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [cfms_pkg::CfgDataWidth-1:0]   cfg_data
);
  import cfms_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    step;
  result_t result;

  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (step) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.switch_one_level   <= s_axis_tdata[0];
      in_item.switch_two_level   <= s_axis_tdata[1];
      in_item.switch_three_level <= s_axis_tdata[2];
      in_item.host_done_level    <= s_axis_tdata[3];
    end
  end

  cfms_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfms_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  assign m_axis_tdata = {4'd0, result.fault_level, result.eject_result,
                         result.eject_result_valid, result.load_result,
                         result.load_result_valid, result.phase, result.card_ready,
                         result.motor_out_on, result.motor_in_on};

  // The core only steps when the result register is free or being drained.
  `CFMS_ASSERT(a_step_fills_output, step |=> m_axis_tvalid,
               "stepped tick did not reach the output register")

  `CFMS_ASSERT(a_stall_holds_core, (m_axis_tvalid && !m_axis_tready) |-> !step,
               "core stepped while the result was stalled")

  `CFMS_ASSERT_ALWAYS(a_reset_empties, rst |=> (!in_valid && !m_axis_tvalid),
                      "pipeline not empty after reset")

endmodule
